[design/crhs_pkg.sv]
// Shared constants, types and codes of the Catmull-Rom Hermite sampler.
package crhs_pkg;

  localparam int COORD_BITS  = 24;
  localparam int T_FRAC_BITS = 16;

  localparam int T_W   = T_FRAC_BITS + 1;
  localparam int D_W   = COORD_BITS + 1;
  localparam int H_W   = T_FRAC_BITS + 4;
  localparam int P_W   = H_W + D_W;
  localparam int S_W   = P_W + 1;
  localparam int E_W   = P_W + 2;
  localparam int SQ_W  = 2 * T_W;
  localparam int SEG_W = 16;

  localparam int MAX_SAMPLES = 64;
  localparam int N_W         = $clog2(MAX_SAMPLES);

  localparam int SEG_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH = 8;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int T_ONE_I   = 1 << T_FRAC_BITS;
  localparam int T_LIMIT_I = T_ONE_I + T_ONE_I / 1000;

  localparam logic [SQ_W-1:0]        SQ_HALF   = SQ_W'(T_ONE_I / 2);
  localparam logic [T_W:0]           T_LIMIT   = (T_W + 1)'(T_LIMIT_I);
  localparam logic [T_W-1:0]         STEP_RST  = T_W'((T_ONE_I + 9) / 10);
  localparam logic signed [H_W-1:0]  H_ONE     = H_W'(T_ONE_I);
  localparam logic signed [E_W-1:0]  E_HALF    = E_W'(T_ONE_I);
  localparam logic [SEG_W-1:0]       COUNT_MAX = '1;

  // register index taken from paddr
  localparam logic REG_STEP_SIZE = 1'b0;

  localparam logic ACT_POINT  = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [D_W-1:0]        diff_t;
  typedef logic signed [H_W-1:0]        basis_t;
  typedef logic signed [P_W-1:0]        prod_t;
  typedef logic signed [S_W-1:0]        psum_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    coord_t           a_x;
    coord_t           a_y;
    coord_t           b_x;
    coord_t           b_y;
    diff_t            d0_x;
    diff_t            d0_y;
    diff_t            d1_x;
    diff_t            d1_y;
  } segment_t;

  typedef struct packed {
    coord_t           curve_x;
    coord_t           curve_y;
    logic [T_W-1:0]   param_t;
    logic [SEG_W-1:0] segment_index;
    logic             last_sample;
  } out_word_t;

endpackage

[design/crhs_fifo.sv]
// Small first-word-fall-through queue with occupancy count.
module crhs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               push_data,
  output logic                           full,
  input  logic                           pop,
  output logic [WIDTH-1:0]               pop_data,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem[rd_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

[design/crhs_front.sv]
// Front end: point window, point count and segment descriptor build.
module crhs_front import crhs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  logic     in_action,
  input  coord_t   in_point_x,
  input  coord_t   in_point_y,
  input  logic     seg_full,
  output logic     seg_push,
  output segment_t seg_data
);

  coord_t           win_x_r [3];
  coord_t           win_y_r [3];
  logic [SEG_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             finish;
  logic             has_seg;

  assign in_full = seg_full;
  assign accept  = in_push & ~seg_full;
  assign finish  = (in_action == ACT_FINISH);
  assign has_seg = (count_r >= SEG_W'(2));

  always_comb begin
    seg_data.seg = count_r - SEG_W'(2);
    seg_data.a_x = win_x_r[1];
    seg_data.a_y = win_y_r[1];
    seg_data.b_x = win_x_r[2];
    seg_data.b_y = win_y_r[2];
    // one-sided tangent at the first point of the curve
    if (count_r == SEG_W'(2)) begin
      seg_data.d0_x = D_W'(win_x_r[2]) - D_W'(win_x_r[1]);
      seg_data.d0_y = D_W'(win_y_r[2]) - D_W'(win_y_r[1]);
    end else begin
      seg_data.d0_x = D_W'(win_x_r[2]) - D_W'(win_x_r[0]);
      seg_data.d0_y = D_W'(win_y_r[2]) - D_W'(win_y_r[0]);
    end
    // one-sided tangent at the last point on finish
    if (finish) begin
      seg_data.d1_x = D_W'(win_x_r[2]) - D_W'(win_x_r[1]);
      seg_data.d1_y = D_W'(win_y_r[2]) - D_W'(win_y_r[1]);
    end else begin
      seg_data.d1_x = D_W'(in_point_x) - D_W'(win_x_r[1]);
      seg_data.d1_y = D_W'(in_point_y) - D_W'(win_y_r[1]);
    end
  end

  assign seg_push = accept & has_seg;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (finish) begin
        count_nxt = '0;
      end else if (count_r != COUNT_MAX) begin
        count_nxt = count_r + SEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // shift the window on every new point
  always_ff @(posedge clk) begin
    if (accept && !finish) begin
      win_x_r[0] <= win_x_r[1];
      win_x_r[1] <= win_x_r[2];
      win_x_r[2] <= in_point_x;
      win_y_r[0] <= win_y_r[1];
      win_y_r[1] <= win_y_r[2];
      win_y_r[2] <= in_point_y;
    end
  end

endmodule

[design/crhs_back.sv]
// Back end: segment sequencer and pipelined Hermite evaluation.
module crhs_back import crhs_pkg::*; #(
  parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [T_W-1:0]                step_size,
  input  logic                          seg_empty,
  input  segment_t                      seg_data,
  output logic                          seg_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                          out_push,
  output out_word_t                     out_data
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [T_W-1:0]  t;
    logic            last;
    segment_t        desc;
    logic [SQ_W-1:0] sq;
  } st1_t;

  typedef struct packed {
    logic [T_W-1:0]  t;
    logic            last;
    segment_t        desc;
    logic [SQ_W-1:0] t3_raw;
    logic [T_W-1:0]  t2;
  } st2_t;

  typedef struct packed {
    logic [T_W-1:0] t;
    logic           last;
    segment_t       desc;
    basis_t         h0;
    basis_t         h1;
    basis_t         h2;
    basis_t         h3;
  } st3_t;

  typedef struct packed {
    logic [T_W-1:0]   t;
    logic             last;
    logic [SEG_W-1:0] seg;
    prod_t            mx0, mx1, mx2, mx3;
    prod_t            my0, my1, my2, my3;
  } st4_t;

  typedef struct packed {
    logic [T_W-1:0]   t;
    logic             last;
    logic [SEG_W-1:0] seg;
    psum_t            sx01, sx23;
    psum_t            sy01, sy23;
  } st5_t;

  seq_state_t       state_r, state_nxt;
  segment_t         desc_r;
  logic [T_W-1:0]   t_r;
  logic [N_W-1:0]   n_r;
  logic [T_W:0]     nt;
  logic             last_c;
  logic             credit_ok;
  logic             issue;
  logic [2:0]       inflight;

  logic             v1_r, v2_r, v3_r, v4_r, v5_r;
  st1_t             s1_r;
  st2_t             s2_r;
  st3_t             s3_r;
  st4_t             s4_r;
  st5_t             s5_r;

  logic [T_W-1:0]   t2_c, t3_c;
  basis_t           ts, t2s, t3s;

  function automatic coord_t round_sat(input psum_t a, input psum_t b);
    logic signed [E_W-1:0] s;
    logic signed [E_W-1:0] r;
    coord_t                res;
    s = E_W'(a) + E_W'(b) + E_HALF;
    r = s >>> (T_FRAC_BITS + 1);
    res = r[COORD_BITS-1:0];
    if (!r[E_W-1] && (|r[E_W-2:COORD_BITS-1])) begin
      res = {1'b0, {(COORD_BITS - 1){1'b1}}};
    end else if (r[E_W-1] && !(&r[E_W-2:COORD_BITS-1])) begin
      res = {1'b1, {(COORD_BITS - 1){1'b0}}};
    end
    return res;
  endfunction

  // ---- sequencer ----
  assign nt       = {1'b0, t_r} + {1'b0, step_size};
  assign last_c   = (nt > T_LIMIT) || (n_r == N_W'(MAX_SAMPLES - 1));
  assign inflight = 3'(v1_r) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r) + 3'(v5_r);
  // reserve a result slot for every sample still in the pipeline
  assign credit_ok = (({1'b0, out_count} + (CW + 1)'(inflight)) < (CW + 1)'(OUT_DEPTH));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (!seg_empty) state_nxt = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (credit_ok && last_c) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    seg_pop = 1'b0;
    issue   = 1'b0;
    unique case (state_r)
      SEQ_IDLE: seg_pop = ~seg_empty;
      SEQ_RUN:  issue   = credit_ok;
      default: begin
        seg_pop = 1'b0;
        issue   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_pop) begin
      desc_r <= seg_data;
      t_r    <= '0;
      n_r    <= '0;
    end else if (issue) begin
      t_r <= nt[T_W-1:0];
      n_r <= n_r + N_W'(1);
    end
  end

  // ---- evaluation pipeline ----
  assign t2_c = T_W'((s1_r.sq + SQ_HALF) >> T_FRAC_BITS);
  assign t3_c = T_W'((s2_r.t3_raw + SQ_HALF) >> T_FRAC_BITS);
  assign ts   = signed'(H_W'(s2_r.t));
  assign t2s  = signed'(H_W'(s2_r.t2));
  assign t3s  = signed'(H_W'(t3_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r.t    <= t_r;
    s1_r.last <= last_c;
    s1_r.desc <= desc_r;
    s1_r.sq   <= SQ_W'(t_r) * SQ_W'(t_r);

    s2_r.t      <= s1_r.t;
    s2_r.last   <= s1_r.last;
    s2_r.desc   <= s1_r.desc;
    s2_r.t2     <= t2_c;
    s2_r.t3_raw <= SQ_W'(t2_c) * SQ_W'(s1_r.t);

    s3_r.t    <= s2_r.t;
    s3_r.last <= s2_r.last;
    s3_r.desc <= s2_r.desc;
    s3_r.h0   <= (t3s <<< 1) - t2s - (t2s <<< 1) + H_ONE;
    s3_r.h1   <= t2s + (t2s <<< 1) - (t3s <<< 1);
    s3_r.h2   <= t3s - (t2s <<< 1) + ts;
    s3_r.h3   <= t3s - t2s;

    s4_r.t    <= s3_r.t;
    s4_r.last <= s3_r.last;
    s4_r.seg  <= s3_r.desc.seg;
    s4_r.mx0  <= P_W'(s3_r.h0) * P_W'(D_W'(s3_r.desc.a_x) <<< 1);
    s4_r.mx1  <= P_W'(s3_r.h1) * P_W'(D_W'(s3_r.desc.b_x) <<< 1);
    s4_r.mx2  <= P_W'(s3_r.h2) * P_W'(s3_r.desc.d0_x);
    s4_r.mx3  <= P_W'(s3_r.h3) * P_W'(s3_r.desc.d1_x);
    s4_r.my0  <= P_W'(s3_r.h0) * P_W'(D_W'(s3_r.desc.a_y) <<< 1);
    s4_r.my1  <= P_W'(s3_r.h1) * P_W'(D_W'(s3_r.desc.b_y) <<< 1);
    s4_r.my2  <= P_W'(s3_r.h2) * P_W'(s3_r.desc.d0_y);
    s4_r.my3  <= P_W'(s3_r.h3) * P_W'(s3_r.desc.d1_y);

    s5_r.t    <= s4_r.t;
    s5_r.last <= s4_r.last;
    s5_r.seg  <= s4_r.seg;
    s5_r.sx01 <= S_W'(s4_r.mx0) + S_W'(s4_r.mx1);
    s5_r.sx23 <= S_W'(s4_r.mx2) + S_W'(s4_r.mx3);
    s5_r.sy01 <= S_W'(s4_r.my0) + S_W'(s4_r.my1);
    s5_r.sy23 <= S_W'(s4_r.my2) + S_W'(s4_r.my3);
  end

  assign out_push               = v5_r;
  assign out_data.curve_x       = round_sat(s5_r.sx01, s5_r.sx23);
  assign out_data.curve_y       = round_sat(s5_r.sy01, s5_r.sy23);
  assign out_data.param_t       = s5_r.t;
  assign out_data.segment_index = s5_r.seg;
  assign out_data.last_sample   = s5_r.last;

endmodule

[design/catmull_rom_hermite_sampler_core.sv]
// Top level of the Catmull-Rom Hermite sampler: config register and queues.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------------
//   in       | in_push / in_full        | in_action, in_point_x, in_point_y
//   out      | out_pop / out_empty      | out_curve_x/y, out_param_t,
//            |                          | out_segment_index, out_last_sample
//   config   | psel, penable, pwrite    | paddr, pwdata, prdata (step_size)
//
// An input word is taken while the segment queue has room. The single sequencer
// loads a segment and then issues its samples (1..64 per segment) into a
// five-stage evaluation pipeline; the result queue depth bounds samples in flight
// and stalls issue when the consumer holds off. Reset is synchronous; there is no
// clearing pass.
module catmull_rom_hermite_sampler_core import crhs_pkg::*; #(
  parameter int SEG_DEPTH = SEG_QUEUE_DEPTH,
  parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic                   in_action,
  input  coord_t                 in_point_x,
  input  coord_t                 in_point_y,
  output logic                   out_empty,
  input  logic                   out_pop,
  output coord_t                 out_curve_x,
  output coord_t                 out_curve_y,
  output logic [T_W-1:0]         out_param_t,
  output logic [SEG_W-1:0]       out_segment_index,
  output logic                   out_last_sample,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  logic [T_W-1:0]               step_r;
  logic                         cfg_wr;
  logic                         seg_push, seg_full, seg_pop, seg_empty;
  segment_t                     seg_wdata, seg_rdata;
  logic                         res_push;
  out_word_t                    res_wdata, res_rdata;
  logic [$clog2(OUT_DEPTH+1)-1:0] res_count;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_STEP_SIZE);
  assign prdata = (paddr[2] == REG_STEP_SIZE) ? PDATA_W'(step_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RST;
    end else if (cfg_wr) begin
      step_r <= pwdata[T_W-1:0];
    end
  end

  crhs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_action  (in_action),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .seg_full   (seg_full),
    .seg_push   (seg_push),
    .seg_data   (seg_wdata)
  );

  crhs_fifo #(
    .WIDTH ($bits(segment_t)),
    .DEPTH (SEG_DEPTH)
  ) u_seg_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (seg_push),
    .push_data (seg_wdata),
    .full      (seg_full),
    .pop       (seg_pop),
    .pop_data  (seg_rdata),
    .empty     (seg_empty),
    .count     ()
  );

  crhs_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_size (step_r),
    .seg_empty (seg_empty),
    .seg_data  (seg_rdata),
    .seg_pop   (seg_pop),
    .out_count (res_count),
    .out_push  (res_push),
    .out_data  (res_wdata)
  );

  crhs_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_wdata),
    .full      (),
    .pop       (out_pop),
    .pop_data  (res_rdata),
    .empty     (out_empty),
    .count     (res_count)
  );

  assign out_curve_x       = res_rdata.curve_x;
  assign out_curve_y       = res_rdata.curve_y;
  assign out_param_t       = res_rdata.param_t;
  assign out_segment_index = res_rdata.segment_index;
  assign out_last_sample   = res_rdata.last_sample;

endmodule

[bench/tb.sv]
// Self-checking testbench for the Catmull-Rom Hermite sampler core.
`timescale 1ns / 100ps

module tb;
  import crhs_pkg::*;

  localparam int LIMIT = 3_000_000;
  localparam int SETTLE = 16;
  localparam logic [PADDR_W-1:0] STEP_ADDR = {REG_STEP_SIZE, 2'b00};
  localparam coord_t CMAX = {1'b0, {23{1'b1}}};
  localparam coord_t CMIN = {1'b1, 23'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_action = ACT_POINT;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  coord_t out_curve_x;
  coord_t out_curve_y;
  logic [T_W-1:0] out_param_t;
  logic [SEG_W-1:0] out_segment_index;
  logic out_last_sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // predictor state
  coord_t win_x[3] = '{default: '0};
  coord_t win_y[3] = '{default: '0};
  logic [SEG_W-1:0] pts_held = '0;
  logic [T_W-1:0] step_len = STEP_RST;

  out_word_t samples_due[$];
  int miss_count = 0;
  int items_sent = 0;
  int cycles = 0;
  int pop_hold = 0;
  bit calm = 1'b0;

  catmull_rom_hermite_sampler_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_action(in_action),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_curve_x(out_curve_x), .out_curve_y(out_curve_y),
    .out_param_t(out_param_t), .out_segment_index(out_segment_index),
    .out_last_sample(out_last_sample),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  task automatic report_miss(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    miss_count++;
  endtask

  function automatic coord_t hermite_coord(longint h0, longint h1, longint h2, longint h3,
                                           longint p0, longint p1, longint d0, longint d1);
    longint acc;
    longint top;
    top = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    acc = (h0 * 2 * p0 + h1 * 2 * p1 + h2 * d0 + h3 * d1 + T_ONE_I) >>> (T_FRAC_BITS + 1);
    if (acc > top) acc = top;
    else if (acc < -top - 1) acc = -top - 1;
    return acc[COORD_BITS-1:0];
  endfunction

  task automatic sample_segment(longint ax, longint ay, longint bx, longint by,
                                longint d0x, longint d0y, longint d1x, longint d1y,
                                logic [SEG_W-1:0] seg);
    longint t, t2, t3, nt, h0, h1, h2, h3;
    int n;
    bit fin;
    out_word_t w;
    t = 0;
    n = 0;
    do begin
      t2 = (t * t + T_ONE_I / 2) >>> T_FRAC_BITS;
      t3 = (t2 * t + T_ONE_I / 2) >>> T_FRAC_BITS;
      h0 = 2 * t3 - 3 * t2 + T_ONE_I;
      h1 = 3 * t2 - 2 * t3;
      h2 = t3 - 2 * t2 + t;
      h3 = t3 - t2;
      nt = t + longint'(step_len);
      fin = (nt > T_LIMIT_I) || (n + 1 >= MAX_SAMPLES);
      w.curve_x = hermite_coord(h0, h1, h2, h3, ax, bx, d0x, d1x);
      w.curve_y = hermite_coord(h0, h1, h2, h3, ay, by, d0y, d1y);
      w.param_t = t[T_W-1:0];
      w.segment_index = seg;
      w.last_sample = fin;
      samples_due.push_back(w);
      n++;
      t = nt;
    end while (!fin);
  endtask

  // Advance the curve window by one accepted word and queue its samples.
  task automatic predict_samples(logic act, coord_t px, coord_t py);
    logic [SEG_W-1:0] k;
    longint ax, ay, bx, by, d0x, d0y;
    k = pts_held;
    ax = win_x[1];
    ay = win_y[1];
    bx = win_x[2];
    by = win_y[2];
    if (k == 16'd2) begin
      d0x = bx - ax;
      d0y = by - ay;
    end else begin
      d0x = bx - longint'(win_x[0]);
      d0y = by - longint'(win_y[0]);
    end
    if (act == ACT_FINISH) begin
      if (k >= 16'd2) sample_segment(ax, ay, bx, by, d0x, d0y, bx - ax, by - ay, k - 16'd2);
      win_x = '{default: '0};
      win_y = '{default: '0};
      pts_held = '0;
    end else begin
      if (k >= 16'd2) sample_segment(ax, ay, bx, by, d0x, d0y, px - ax, py - ay, k - 16'd2);
      win_x[0] = win_x[1];
      win_x[1] = win_x[2];
      win_x[2] = px;
      win_y[0] = win_y[1];
      win_y[1] = win_y[2];
      win_y[2] = py;
      if (pts_held != COUNT_MAX) pts_held++;
    end
  endtask

  task automatic send_word(logic act, coord_t px, coord_t py);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_action <= act;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (in_full);
    items_sent++;
    predict_samples(act, px, py);
  endtask

  // Hold the sender until every queued sample is out, then let the core settle.
  task automatic drain_results();
    in_push <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_step_reg();
    logic [PDATA_W-1:0] rd;
    apb_read(STEP_ADDR, rd);
    if (rd[T_W-1:0] !== step_len)
      report_miss($sformatf("step_size read %0d, written %0d", rd[T_W-1:0], step_len));
  endtask

  task automatic set_step(logic [PDATA_W-1:0] v);
    drain_results();
    apb_write(STEP_ADDR, v);
    step_len = v[T_W-1:0];
    check_step_reg();
  endtask

  function automatic coord_t pick_coord(coord_t near);
    logic [31:0] r;
    coord_t c;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: c = r[23:0];
      3, 4:    c = {{11{r[12]}}, r[12:0]};
      5:       c = r[0] ? CMAX : CMIN;
      default: c = near + {{14{r[9]}}, r[9:0]};
    endcase
    return c;
  endfunction

  // result side: random stalls unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      out_pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_pop <= 1'b0;
      pop_hold <= $urandom_range(0, 17);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && out_pop && !out_empty) begin
      if (samples_due.size() == 0) begin
        report_miss($sformatf("unexpected sample seg %0d t %0d", out_segment_index,
                              out_param_t));
      end else begin
        w = samples_due.pop_front();
        if (out_curve_x !== w.curve_x)
          report_miss($sformatf("curve_x got %0d want %0d", out_curve_x, w.curve_x));
        if (out_curve_y !== w.curve_y)
          report_miss($sformatf("curve_y got %0d want %0d", out_curve_y, w.curve_y));
        if (out_param_t !== w.param_t)
          report_miss($sformatf("param_t got %0d want %0d", out_param_t, w.param_t));
        if (out_segment_index !== w.segment_index)
          report_miss($sformatf("segment_index got %0d want %0d", out_segment_index,
                                w.segment_index));
        if (out_last_sample !== w.last_sample)
          report_miss($sformatf("last_sample got %0b want %0b", out_last_sample,
                                w.last_sample));
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_step_reset();
    check_step_reg();
  endtask

  // finish with nothing held, with one point, then minimal curves
  task automatic test_short_curves();
    send_word(ACT_FINISH, pick_coord('0), pick_coord('0));
    send_word(ACT_POINT, 24'sd1000, -24'sd500);
    send_word(ACT_FINISH, pick_coord('0), pick_coord('0));
    send_word(ACT_POINT, -24'sd2560, 24'sd256);
    send_word(ACT_POINT, 24'sd7680, 24'sd5120);
    send_word(ACT_FINISH, '0, '0);
    send_word(ACT_POINT, 24'sd0, 24'sd0);
    send_word(ACT_POINT, 24'sd25600, -24'sd12800);
    send_word(ACT_POINT, -24'sd6400, 24'sd51200);
    send_word(ACT_FINISH, CMAX, CMIN);
  endtask

  // full-scale zigzag overshoots between samples and must clip
  task automatic test_saturation();
    set_step(32'd1040);
    send_word(ACT_POINT, CMAX, CMIN);
    send_word(ACT_POINT, CMIN, CMAX);
    send_word(ACT_POINT, CMAX, CMIN);
    send_word(ACT_POINT, CMIN, CMAX);
    send_word(ACT_FINISH, CMIN, CMIN);
  endtask

  // zero step hits the sample cap; the limit itself is inclusive; oversize gives one sample
  task automatic test_step_extremes();
    logic [PDATA_W-1:0] steps[3];
    steps = '{32'd0, 32'(T_LIMIT_I), 32'hFFFF_FFFF};
    foreach (steps[i]) begin
      set_step(steps[i]);
      send_word(ACT_POINT, pick_coord('0), pick_coord('0));
      send_word(ACT_POINT, pick_coord('0), pick_coord('0));
      send_word(ACT_FINISH, pick_coord('0), pick_coord('0));
    end
  endtask

  task automatic random_curve();
    int npts;
    int shape;
    coord_t x, y;
    x = '0;
    y = '0;
    shape = $urandom_range(0, 19);
    if (shape < 14) npts = $urandom_range(2, 6);
    else if (shape < 17) npts = $urandom_range(0, 1);
    else npts = $urandom_range(7, 12);
    for (int i = 0; i < npts; i++) begin
      x = pick_coord(x);
      y = pick_coord(y);
      send_word(ACT_POINT, x, y);
    end
    // leave some curves open so the next one runs on from them
    if ($urandom_range(0, 9) != 0) send_word(ACT_FINISH, pick_coord(x), pick_coord(y));
    if ($urandom_range(0, 15) == 0) send_word(ACT_FINISH, pick_coord(x), pick_coord(y));
  endtask

  task automatic test_random_curves();
    int start;
    start = items_sent;
    while (items_sent - start < 190) begin
      case ($urandom_range(0, 9))
        0:       set_step(32'd1040);
        1:       set_step(32'd65536);
        2:       set_step($urandom_range(0, 1039));
        3:       set_step($urandom_range(T_LIMIT_I + 1, 131071));
        4:       set_step(32'(T_LIMIT_I));
        default: set_step($urandom_range(3000, 40000));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 6)) random_curve();
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_calm_tail();
    set_step($urandom_range(3000, 40000));
    calm = 1'b1;
    repeat (5) random_curve();
    send_word(ACT_FINISH, '0, '0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_step_reset();
    test_short_curves();
    test_saturation();
    test_step_extremes();
    test_random_curves();
    test_calm_tail();
    drain_results();
    if (miss_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/crhs_pkg.sv
design/crhs_fifo.sv
design/crhs_front.sv
design/crhs_back.sv
design/catmull_rom_hermite_sampler_core.sv
bench/tb.sv
